/* hw/rtl/lir_pkg.sv */
// Shared types, widths and codes for the linear interpolation resampler.
package lir_pkg;

	// Field and register widths
	localparam int SAMPLE_W     = 16;
	localparam int RATE_W       = 18;
	localparam int REM_W        = RATE_W + 1;
	localparam int CNT_BITS_DEF = 32;
	localparam int PADDR_W      = 3;
	localparam int PDATA_W      = 32;

	// Rate limits and reset values
	localparam logic [RATE_W-1:0] RATE_MIN     = 18'd8000;
	localparam logic [RATE_W-1:0] RATE_MAX     = 18'd192000;
	localparam logic [RATE_W-1:0] IN_RATE_RST  = 18'd16000;
	localparam logic [RATE_W-1:0] OUT_RATE_RST = 18'd48000;

	// Register indexes (word address bits of paddr)
	localparam logic REG_IN_RATE  = 1'b0;
	localparam logic REG_OUT_RATE = 1'b1;

	// Interpolation arithmetic widths
	localparam int PROD_W    = SAMPLE_W + RATE_W + 1;
	localparam int SUM_W     = PROD_W + 1;
	localparam int MAG_W     = 33;
	localparam int DIVD_W    = MAG_W + 1;
	localparam int QUO_W     = SAMPLE_W;
	localparam int DIV_STEPS = QUO_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// Input and result words
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_in;
		logic                       stream_last;
	} src_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       sample_valid;
		logic                       run_last;
		logic                       stream_end;
	} dst_word_t;

	// Source of a result put into the pending slot
	typedef enum logic [1:0] {
		PUT_HELD,
		PUT_X,
		PUT_ZERO
	} put_src_t;

	// Controller to datapath commands
	typedef struct packed {
		logic     latch;
		logic     sub_step;
		logic     commit;
		logic     mul;
		logic     sum;
		logic     div_step;
		logic     put;
		put_src_t put_src;
		logic     hold_new;
		logic     hold_x;
		logic     finish;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic eq_rates;
		logic rem_ge_ro;
		logic hit_km1;
		logic have_prev;
		logic tail_hit;
		logic held_valid;
		logic pend_valid;
		logic out_free;
		logic last;
	} dp_status_t;

endpackage

/* hw/rtl/lir_cfg.sv */
// APB register file for the input and output rates, with clamped rate outputs.
module lir_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lir_pkg::PADDR_W-1:0]   paddr,
	input  logic [lir_pkg::PDATA_W-1:0]   pwdata,
	output logic [lir_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [lir_pkg::RATE_W-1:0]    in_rate_eff,
	output logic [lir_pkg::RATE_W-1:0]    out_rate_eff
);
	import lir_pkg::*;

	logic [RATE_W-1:0] in_rate_q;
	logic [RATE_W-1:0] out_rate_q;
	logic              reg_idx;
	logic              wr_en;

	function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r);
		logic [RATE_W-1:0] c;
		c = r;
		if (r < RATE_MIN) c = RATE_MIN;
		if (r > RATE_MAX) c = RATE_MAX;
		return c;
	endfunction

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1];
	assign wr_en   = psel & penable & pwrite & pready;

	// Write the addressed rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_rate_q  <= IN_RATE_RST;
			out_rate_q <= OUT_RATE_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_IN_RATE:  in_rate_q  <= pwdata[RATE_W-1:0];
				REG_OUT_RATE: out_rate_q <= pwdata[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the raw register value
	always_comb begin
		case (reg_idx)
			REG_IN_RATE:  prdata = PDATA_W'(in_rate_q);
			REG_OUT_RATE: prdata = PDATA_W'(out_rate_q);
			default:      prdata = '0;
		endcase
	end

	// Saturate rates to the supported range
	assign in_rate_eff  = clamp_rate(in_rate_q);
	assign out_rate_eff = clamp_rate(out_rate_q);

endmodule

/* hw/rtl/lir_ctrl.sv */
// Sequencing state machine that steps the datapath through one input word.
module lir_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_ready,
	input  lir_pkg::dp_status_t status,
	output lir_pkg::dp_cmd_t    cmd
);
	import lir_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EQ,
		ST_FOLD,
		ST_CHK_A,
		ST_MUL,
		ST_SUM,
		ST_DIV,
		ST_EMIT,
		ST_ADV,
		ST_CHK_B,
		ST_TAIL,
		ST_ZERO,
		ST_FIN
	} state_t;

	state_t            state_q, state_d;
	logic              phase_b_q, phase_b_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              can_push;

	// A put may move the pending word out only when the output slot frees
	assign can_push = !status.pend_valid || status.out_free;

	// Decode commands and next state
	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		phase_b_d = phase_b_q;
		step_d    = step_q;
		src_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				src_ready = 1'b1;
				if (src_valid) begin
					cmd.latch = 1'b1;
					state_d   = status.eq_rates ? ST_EQ : ST_FOLD;
				end
			end
			ST_EQ: begin
				if (can_push) begin
					cmd.put     = 1'b1;
					cmd.put_src = PUT_X;
					state_d     = ST_FIN;
				end
			end
			ST_FOLD: begin
				if (status.rem_ge_ro) cmd.sub_step = 1'b1;
				else state_d = ST_CHK_A;
			end
			ST_CHK_A: begin
				if (status.have_prev && status.hit_km1) begin
					phase_b_d = 1'b0;
					state_d   = ST_MUL;
				end else begin
					cmd.commit = 1'b1;
					state_d    = status.last ? ST_CHK_B : ST_FIN;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				step_d  = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) state_d = ST_EMIT;
				else step_d = step_q + STEP_W'(1);
			end
			ST_EMIT: begin
				// release the held output, hold the new one, start the advance
				if (!(status.held_valid && status.pend_valid) || status.out_free) begin
					cmd.put      = status.held_valid;
					cmd.put_src  = PUT_HELD;
					cmd.hold_new = 1'b1;
					cmd.hold_x   = phase_b_q;
					state_d      = ST_ADV;
				end
			end
			ST_ADV: begin
				if (status.rem_ge_ro) cmd.sub_step = 1'b1;
				else state_d = phase_b_q ? ST_CHK_B : ST_CHK_A;
			end
			ST_CHK_B: begin
				if (status.hit_km1) begin
					phase_b_d = 1'b1;
					state_d   = ST_EMIT;
				end else begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL: begin
				if (!status.tail_hit) begin
					state_d = ST_ZERO;
				end else if (can_push) begin
					cmd.put     = 1'b1;
					cmd.put_src = PUT_HELD;
					state_d     = ST_ZERO;
				end
			end
			ST_ZERO: begin
				// a stream end with no sample still gets a bare end marker
				if (!status.pend_valid) begin
					cmd.put     = 1'b1;
					cmd.put_src = PUT_ZERO;
				end
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (can_push) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state, phase flag and divider step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_b_q <= 1'b0;
			step_q    <= '0;
		end else begin
			state_q   <= state_d;
			phase_b_q <= phase_b_d;
			step_q    <= step_d;
		end
	end

endmodule

/* hw/rtl/lir_datapath.sv */
// Position tracking, interpolation multiply, restoring divider and result buffering.
module lir_datapath #(
	parameter int COUNT_BITS = lir_pkg::CNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lir_pkg::src_word_t          src_word,
	input  logic [lir_pkg::RATE_W-1:0]  in_rate_eff,
	input  logic [lir_pkg::RATE_W-1:0]  out_rate_eff,
	input  lir_pkg::dp_cmd_t            cmd,
	output lir_pkg::dp_status_t         status,
	output logic                        dst_valid,
	input  logic                        dst_ready,
	output lir_pkg::dst_word_t          dst_word
);
	import lir_pkg::*;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] smp;
		logic                       vld;
	} pend_t;

	// Input word and stream state
	logic signed [SAMPLE_W-1:0] x_q;
	logic                       last_q;
	logic signed [SAMPLE_W-1:0] prev_q;
	logic                       have_prev_q;
	logic [COUNT_BITS-1:0]      seen_q;
	logic [COUNT_BITS-1:0]      idx_q;
	logic [REM_W-1:0]           rem_q;
	logic signed [SAMPLE_W-1:0] held_q;
	logic                       held_valid_q;

	// Pending and output words
	pend_t                      pend_q;
	logic                       pend_valid_q;
	dst_word_t                  out_q;
	logic                       out_valid_q;

	// Arithmetic pipeline and divider
	logic signed [PROD_W-1:0]   prod_a_s1, prod_b_s1;
	logic                       neg_s2;
	logic [DIVD_W-1:0]          rmd_q, dsh_q;
	logic [QUO_W-1:0]           quo_q;

	logic [REM_W-1:0]           ro_ext, ri_ext;
	logic [RATE_W-1:0]          rem_lo;
	logic signed [RATE_W:0]     wt_a, wt_b;
	logic signed [PROD_W-1:0]   prod_a, prod_b;
	logic signed [SUM_W-1:0]    num;
	logic [SUM_W-1:0]           mag_full;
	logic [MAG_W-1:0]           mag;
	logic [DIVD_W-1:0]          dividend, dsh_init;
	logic                       div_ge;
	logic signed [SAMPLE_W-1:0] interp_val;
	pend_t                      put_val;
	logic                       out_load;
	logic                       clear;

	assign ro_ext = {1'b0, out_rate_eff};
	assign ri_ext = {1'b0, in_rate_eff};
	assign rem_lo = rem_q[RATE_W-1:0];

	// Weights a*(out-r) and b*r
	assign wt_a   = $signed({1'b0, out_rate_eff - rem_lo});
	assign wt_b   = $signed({1'b0, rem_lo});
	assign prod_a = PROD_W'(prev_q) * PROD_W'(wt_a);
	assign prod_b = PROD_W'(x_q) * PROD_W'(wt_b);

	// Magnitude and rounding offset for the divide
	assign num      = SUM_W'(prod_a_s1) + SUM_W'(prod_b_s1);
	assign mag_full = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
	assign mag      = mag_full[MAG_W-1:0];
	assign dividend = {mag, 1'b0} + DIVD_W'(out_rate_eff);
	assign dsh_init = {out_rate_eff, 1'b0, {(QUO_W-1){1'b0}}};
	assign div_ge   = rmd_q >= dsh_q;

	assign interp_val = neg_s2 ? $signed(QUO_W'(0) - quo_q) : $signed(quo_q);

	// Select the word to put into the pending slot
	always_comb begin
		case (cmd.put_src)
			PUT_HELD: put_val = '{smp: held_q, vld: 1'b1};
			PUT_X:    put_val = '{smp: x_q, vld: 1'b1};
			PUT_ZERO: put_val = '{smp: '0, vld: 1'b0};
			default:  put_val = '{smp: '0, vld: 1'b0};
		endcase
	end

	assign out_load = (cmd.put || cmd.finish) && pend_valid_q;
	assign clear    = cmd.finish && last_q;

	// Latch the accepted input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			last_q <= 1'b0;
		end else if (cmd.latch) begin
			x_q    <= src_word.sample_in;
			last_q <= src_word.stream_last;
		end
	end

	// Advance position, commit samples, hold outputs, clear at stream end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q       <= '0;
			have_prev_q  <= 1'b0;
			seen_q       <= '0;
			idx_q        <= '0;
			rem_q        <= '0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
		end else if (clear) begin
			prev_q       <= '0;
			have_prev_q  <= 1'b0;
			seen_q       <= '0;
			idx_q        <= '0;
			rem_q        <= '0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
		end else begin
			if (cmd.sub_step) begin
				rem_q <= rem_q - ro_ext;
				idx_q <= idx_q + COUNT_BITS'(1);
			end
			if (cmd.hold_new) begin
				held_q       <= cmd.hold_x ? x_q : interp_val;
				held_valid_q <= 1'b1;
				rem_q        <= rem_q + ri_ext;
			end
			if (cmd.commit) begin
				prev_q      <= x_q;
				have_prev_q <= 1'b1;
				seen_q      <= seen_q + COUNT_BITS'(1);
			end
		end
	end

	// Multiply, sum and shift-subtract divide
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_a_s1 <= prod_a;
			prod_b_s1 <= prod_b;
		end
		if (cmd.sum) begin
			neg_s2 <= num[SUM_W-1];
			rmd_q  <= dividend;
			dsh_q  <= dsh_init;
		end else if (cmd.div_step) begin
			if (div_ge) rmd_q <= rmd_q - dsh_q;
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QUO_W-2:0], div_ge};
		end
	end

	// Pending slot: one result waits so the last of a run can be flagged
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.put) begin
			pend_valid_q <= 1'b1;
		end else if (cmd.finish) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put) pend_q <= put_val;
	end

	// Output register: load from the pending slot, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (dst_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.sample_out   <= pend_q.smp;
			out_q.sample_valid <= pend_q.vld;
			out_q.run_last     <= cmd.finish;
			out_q.stream_end   <= cmd.finish && last_q;
		end
	end

	assign dst_valid = out_valid_q;
	assign dst_word  = out_q;

	// Status for the controller
	always_comb begin
		status.eq_rates   = in_rate_eff == out_rate_eff;
		status.rem_ge_ro  = rem_q >= ro_ext;
		status.hit_km1    = idx_q == (seen_q - COUNT_BITS'(1));
		status.have_prev  = have_prev_q;
		status.tail_hit   = held_valid_q && (idx_q == seen_q) && (rem_q == '0);
		status.held_valid = held_valid_q;
		status.pend_valid = pend_valid_q;
		status.out_free   = !out_valid_q || dst_ready;
		status.last       = last_q;
	end

endmodule

/* hw/rtl/linear_interp_resampler.sv */
// Linear interpolation sample rate converter: top level.
//
// Input words (src_*) carry one signed 16-bit PCM sample and a stream_last
// flag; result words (dst_*) carry the resampled sample, sample_valid,
// run_last (last result of one input word) and stream_end. Both channels use
// valid/ready. Rates are set over the APB port (in_rate at 0x0, out_rate at
// 0x4) and are saturated to 8000..192000 Hz.
// One input word is processed at a time. With equal rates a word passes
// through, and the next word is taken only after its result has moved to
// the output register. Otherwise each interpolated result takes a check, a
// multiply, a sum, a restoring divide, the hand-off to the held slot and the
// position advance, which subtracts out_rate once per step; each word also
// adds bookkeeping and the remainder fold.
// A stalled receiver holds the output register; the engine waits at its next
// result until the register frees. Reset restores 16000/48000 Hz and clears
// all stream state; no clearing pass is needed.
module linear_interp_resampler #(
	parameter int COUNT_BITS = lir_pkg::CNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        src_valid,
	output logic                        src_ready,
	input  lir_pkg::src_word_t          src_word,
	output logic                        dst_valid,
	input  logic                        dst_ready,
	output lir_pkg::dst_word_t          dst_word,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lir_pkg::PADDR_W-1:0] paddr,
	input  logic [lir_pkg::PDATA_W-1:0] pwdata,
	output logic [lir_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import lir_pkg::*;

	logic [RATE_W-1:0] in_rate_eff;
	logic [RATE_W-1:0] out_rate_eff;
	dp_cmd_t           cmd;
	dp_status_t        status;

	lir_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_rate_eff  (in_rate_eff),
		.out_rate_eff (out_rate_eff)
	);

	lir_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.status    (status),
		.cmd       (cmd)
	);

	lir_datapath #(
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_word     (src_word),
		.in_rate_eff  (in_rate_eff),
		.out_rate_eff (out_rate_eff),
		.cmd          (cmd),
		.status       (status),
		.dst_valid    (dst_valid),
		.dst_ready    (dst_ready),
		.dst_word     (dst_word)
	);

endmodule

/* hw/rtl/lir_checker.sv */
// Port-level assertions for the resampler and the bind that attaches them.
module lir_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        src_valid,
	input logic                        src_ready,
	input logic                        dst_valid,
	input logic                        dst_ready,
	input lir_pkg::dst_word_t          dst_word
);
	import lir_pkg::*;

	// Hold a stalled result word
	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |=> dst_valid && $stable(dst_word))
		else $error("result word changed or dropped while stalled");

	// A bare end marker closes both the run and the stream with a zero sample
	a_bare_end: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_word.sample_valid |->
			dst_word.run_last && dst_word.stream_end && (dst_word.sample_out == '0))
		else $error("bare end marker malformed");

	// Stream end is always the last result of its input word
	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_word.stream_end |-> dst_word.run_last)
		else $error("stream_end without run_last");

	// Only one input word is in work at a time
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_ready |=> !src_ready)
		else $error("input accepted while a word is in work");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (.*);

/* test/resample_checker.sv */
`timescale 1ns / 1ps
// Resampler checker: tracks the rate registers, predicts result words and compares them.
module resample_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        src_valid,
	input  logic                        src_ready,
	input  lir_pkg::src_word_t          src_word,
	input  logic                        dst_valid,
	input  logic                        dst_ready,
	input  lir_pkg::dst_word_t          dst_word,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lir_pkg::PADDR_W-1:0] paddr,
	input  logic [lir_pkg::PDATA_W-1:0] pwdata,
	input  logic                        pready,
	output int                          error_count,
	output int                          results_due
);
	import lir_pkg::*;

	localparam int MAX_REPORTS = 10;

	// Rate registers as last written, raw 18-bit values
	logic [RATE_W-1:0] in_rate_q;
	logic [RATE_W-1:0] out_rate_q;

	// Stream position and history
	logic signed [SAMPLE_W-1:0] prev_sample;
	logic signed [SAMPLE_W-1:0] held_sample;
	logic                       have_prev;
	logic                       held_valid;
	logic [CNT_BITS_DEF-1:0]    seen_count;
	logic [CNT_BITS_DEF-1:0]    pos_index;
	logic [RATE_W-1:0]          pos_rem;

	// Words due from the block, oldest first, and the words of the current source word
	dst_word_t resampled_due[$];
	dst_word_t run_words[$];
	dst_word_t due_word;
	int        mismatch_total;

	function automatic logic [RATE_W-1:0] saturate_rate(input logic [RATE_W-1:0] r);
		if (r < RATE_MIN) return RATE_MIN;
		if (r > RATE_MAX) return RATE_MAX;
		return r;
	endfunction

	function automatic void clear_stream();
		prev_sample = '0;
		held_sample = '0;
		have_prev = 1'b0;
		held_valid = 1'b0;
		seen_count = '0;
		pos_index = '0;
		pos_rem = '0;
	endfunction

	// Weighted mean of a and b at remainder r, rounded half away from zero
	function automatic logic signed [SAMPLE_W-1:0] blend(input logic signed [SAMPLE_W-1:0] a,
			input logic signed [SAMPLE_W-1:0] b, input logic [RATE_W-1:0] r,
			input logic [RATE_W-1:0] ro);
		longint wa, wb, wr, wo, num, mag, q;
		wa = a;
		wb = b;
		wr = r;
		wo = ro;
		num = wa * (wo - wr) + wb * wr;
		mag = (num < 0) ? -num : num;
		q = (2 * mag + wo) / (2 * wo);
		return (num < 0) ? SAMPLE_W'(-q) : SAMPLE_W'(q);
	endfunction

	function automatic void add_run_word(input logic signed [SAMPLE_W-1:0] s, input logic valid);
		dst_word_t w;
		w = '0;
		w.sample_out = s;
		w.sample_valid = valid;
		run_words = {run_words, w};
	endfunction

	// Release the held output, hold the new one, advance the position
	function automatic void release_and_hold(input logic signed [SAMPLE_W-1:0] v,
			input logic [RATE_W-1:0] ri, input logic [RATE_W-1:0] ro);
		logic [RATE_W:0] acc;
		if (held_valid) add_run_word(held_sample, 1'b1);
		held_sample = v;
		held_valid = 1'b1;
		acc = {1'b0, pos_rem} + ri;
		pos_index = pos_index + CNT_BITS_DEF'(acc / ro);
		pos_rem = RATE_W'(acc % ro);
	endfunction

	function automatic void resample_word(input src_word_t w);
		logic [RATE_W-1:0]       ri;
		logic [RATE_W-1:0]       ro;
		logic [CNT_BITS_DEF-1:0] k;
		int                      tail_at;
		ri = saturate_rate(in_rate_q);
		ro = saturate_rate(out_rate_q);
		run_words.delete();
		if (ri == ro) begin
			// pass through; the end of stream drops any held output
			add_run_word(w.sample_in, 1'b1);
			if (w.stream_last) clear_stream();
		end else begin
			// fold a remainder left too large by a rate change
			if (pos_rem >= ro) begin
				pos_index = pos_index + CNT_BITS_DEF'(pos_rem / ro);
				pos_rem = pos_rem % ro;
			end
			k = seen_count;
			if (have_prev) begin
				while (pos_index == k - CNT_BITS_DEF'(1))
					release_and_hold(blend(prev_sample, w.sample_in, pos_rem, ro), ri, ro);
			end
			prev_sample = w.sample_in;
			have_prev = 1'b1;
			seen_count = k + CNT_BITS_DEF'(1);
			if (w.stream_last) begin
				// repeat the last sample past the end, then flush what is kept
				while (pos_index == k)
					release_and_hold(w.sample_in, ri, ro);
				if (held_valid && pos_index == seen_count && pos_rem == '0)
					add_run_word(held_sample, 1'b1);
				if (run_words.size() == 0) add_run_word('0, 1'b0);
			end
		end
		if (run_words.size() > 0) begin
			tail_at = run_words.size() - 1;
			run_words[tail_at].run_last = 1'b1;
			run_words[tail_at].stream_end = w.stream_last;
		end
		if (w.stream_last) clear_stream();
		resampled_due = {resampled_due, run_words};
	endfunction

	function automatic void note_mismatch(input string what, input dst_word_t want,
			input dst_word_t got);
		mismatch_total++;
		if (mismatch_total <= MAX_REPORTS)
			$display({"%0t %s: expected out=%0d valid=%b run_last=%b end=%b, ",
				"got out=%0d valid=%b run_last=%b end=%b"},
				$time, what, want.sample_out, want.sample_valid, want.run_last,
				want.stream_end, got.sample_out, got.sample_valid, got.run_last,
				got.stream_end);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_rate_q = IN_RATE_RST;
			out_rate_q = OUT_RATE_RST;
			clear_stream();
			resampled_due.delete();
			mismatch_total = 0;
			error_count <= 0;
			results_due <= 0;
		end else begin
			// track register writes
			if (psel && penable && pwrite && pready) begin
				if (paddr[PADDR_W-1:2] == REG_OUT_RATE) out_rate_q = pwdata[RATE_W-1:0];
				else in_rate_q = pwdata[RATE_W-1:0];
			end
			// predict the words caused by an accepted source word
			if (src_valid && src_ready) resample_word(src_word);
			// compare an accepted result word with the oldest one due
			if (dst_valid && dst_ready) begin
				if (resampled_due.size() == 0) begin
					note_mismatch("unexpected result word", '0, dst_word);
				end else begin
					due_word = resampled_due.pop_front();
					if (due_word.sample_out !== dst_word.sample_out ||
							due_word.sample_valid !== dst_word.sample_valid ||
							due_word.run_last !== dst_word.run_last ||
							due_word.stream_end !== dst_word.stream_end)
						note_mismatch("result word mismatch", due_word, dst_word);
				end
			end
			error_count <= mismatch_total;
			results_due <= resampled_due.size();
		end
	end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Testbench top for the resampler: clock, reset, stimulus and the verdict.
module testbench;
	import lir_pkg::*;

	localparam int CYCLE_LIMIT   = 6000000;
	localparam int SETTLE_CYCLES = 400;
	localparam int PHASE_ITEMS   = 130;
	localparam logic signed [SAMPLE_W-1:0] PCM_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] PCM_MIN = 16'sh8000;
	localparam int unsigned STD_RATES [12] = '{8000, 11025, 16000, 22050, 24000, 32000,
		44100, 48000, 88200, 96000, 176400, 192000};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 src_valid = 1'b0;
	logic                 src_ready;
	src_word_t            src_word = '0;
	logic                 dst_valid;
	logic                 dst_ready = 1'b0;
	dst_word_t            dst_word;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [PDATA_W-1:0]   pwdata = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	int                   error_count;
	int                   results_due;
	int                   src_idle_pct = 0;
	int                   dst_idle_pct = 0;
	int                   cycle_count = 0;

	linear_interp_resampler i_dut (
		.clk, .arst_n, .src_valid, .src_ready, .src_word, .dst_valid, .dst_ready, .dst_word,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	resample_checker i_checker (
		.clk, .arst_n, .src_valid, .src_ready, .src_word, .dst_valid, .dst_ready, .dst_word,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready, .error_count, .results_due
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Stall the receiver at random
	always @(posedge clk) begin
		dst_ready <= ($urandom_range(99, 0) >= dst_idle_pct);
	end

	// End a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("linear_interp_resampler verification failed");
			$finish;
		end
	end

	// Write one rate register; bits above the rate field carry noise
	task automatic write_rate(input logic which, input logic [RATE_W-1:0] rate);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {which, 2'b00};
		pwdata <= ($urandom() << RATE_W) | rate;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one source word after a random gap and hold it until accepted
	task automatic push_word(input logic signed [SAMPLE_W-1:0] s, input logic last);
		int gap;
		gap = 0;
		while ($urandom_range(99, 0) < src_idle_pct) gap++;
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_word <= '{sample_in: s, stream_last: last};
		do @(posedge clk); while (!src_ready);
	endtask

	// Hold the sender until every word due has come, then let the engine go quiet
	task automatic settle();
		src_valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [RATE_W-1:0] pick_rate();
		int unsigned roll;
		roll = $urandom_range(19, 0);
		if (roll == 0) return RATE_W'($urandom_range(RATE_MIN - 1, 0));
		if (roll == 1) return RATE_W'($urandom_range((1 << RATE_W) - 1, RATE_MAX + 1));
		return RATE_W'(STD_RATES[$urandom_range(11, 0)]);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9, 0))
			0: return PCM_MAX;
			1: return PCM_MIN;
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	initial begin
		int                sent;
		int                len;
		int                break_at;
		logic [RATE_W-1:0] rate_a;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset rates: extremes, then a one-word stream
		push_word(PCM_MAX, 1'b0);
		push_word(PCM_MIN, 1'b1);
		push_word('0, 1'b1);
		settle();

		// downsample: a lone end word yields a bare end marker
		write_rate(REG_IN_RATE, 18'd48000);
		write_rate(REG_OUT_RATE, 18'd8000);
		push_word(-16'sd1, 1'b1);
		push_word(PCM_MAX, 1'b0);
		push_word(PCM_MIN, 1'b0);
		push_word(PCM_MAX, 1'b1);
		settle();

		// largest upsampling ratio, full swing
		write_rate(REG_IN_RATE, 18'd8000);
		write_rate(REG_OUT_RATE, 18'd192000);
		push_word(PCM_MIN, 1'b0);
		push_word(PCM_MAX, 1'b1);
		settle();

		// leave an output held, then switch to rates equal after saturation
		write_rate(REG_IN_RATE, 18'd44100);
		write_rate(REG_OUT_RATE, 18'd48000);
		push_word(16'sd100, 1'b0);
		push_word(-16'sd200, 1'b0);
		settle();
		write_rate(REG_IN_RATE, 18'd1000);
		write_rate(REG_OUT_RATE, 18'd7999);
		push_word(16'sd300, 1'b0);
		push_word(-16'sd300, 1'b1);
		settle();

		// shrink out_rate mid-stream so the remainder must fold
		write_rate(REG_IN_RATE, 18'd44100);
		write_rate(REG_OUT_RATE, 18'd96000);
		push_word(16'sd5, 1'b0);
		push_word(16'sd6, 1'b0);
		push_word(16'sd7, 1'b0);
		settle();
		write_rate(REG_OUT_RATE, 18'd11025);
		push_word(16'sd8, 1'b0);
		push_word(16'sd9, 1'b1);
		settle();

		// rates beyond both limits
		write_rate(REG_IN_RATE, 18'h3FFFF);
		write_rate(REG_OUT_RATE, 18'd0);
		push_word(16'sd3, 1'b0);
		push_word(-16'sd3, 1'b0);
		push_word(PCM_MAX, 1'b1);
		settle();

		// random streams under three idling patterns
		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 77 : 0;
			dst_idle_pct <= (phase == 0) ? 77 : (phase == 1) ? 30 : 0;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(3, 0) != 0) begin
					settle();
					rate_a = pick_rate();
					write_rate(REG_IN_RATE, rate_a);
					write_rate(REG_OUT_RATE, ($urandom_range(7, 0) == 0) ? rate_a : pick_rate());
				end
				len = ($urandom_range(5, 0) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
				break_at = (len > 1 && $urandom_range(4, 0) == 0) ? $urandom_range(len, 2) : 0;
				for (int i = 1; i <= len; i++) begin
					// change rates between two words of one stream
					if (i == break_at) begin
						settle();
						write_rate(REG_OUT_RATE, pick_rate());
						if ($urandom_range(1, 0) != 0) write_rate(REG_IN_RATE, pick_rate());
					end
					push_word(pick_sample(), i == len);
					sent++;
				end
			end
		end

		settle();
		if (error_count == 0) begin
			$display("linear_interp_resampler verification clean");
		end else begin
			$display("linear_interp_resampler verification failed");
		end
		$finish;
	end

endmodule
